@@ hdl/bavg3_pkg.sv @@
`default_nettype none

package bavg3_pkg;

  // Fixed field widths
  localparam int PIXEL_W = 16;
  localparam int HSUM_W  = PIXEL_W + 2;  // three pixels
  localparam int SUM_W   = PIXEL_W + 4;  // nine pixels
  localparam int MEAN_W  = 20;
  localparam int GRID_W  = 9;
  localparam int CFG_W   = 11;
  localparam int CFG_AW  = 1;
  localparam int OUT_TDATA_W = 40;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int RST_DIM        = 1024;

  // Output queue entries; also the number of results allowed in flight
  localparam int OUT_DEPTH = 4;

  typedef enum logic [CFG_AW-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [GRID_W-1:0] col;
    logic [GRID_W-1:0] row;
    logic              row_last;
    logic              frame_last;
  } meta_t;

  // Line store update request for one completed block row
  typedef struct packed {
    logic                     vld;
    logic                     first;  // top row of the band: no accumulate
    logic                     emit;   // bottom row of the band: block done
    logic signed [HSUM_W-1:0] hsum;
    meta_t                    meta;
  } line_req_t;

  typedef struct packed {
    logic                    vld;
    logic signed [SUM_W-1:0] total;
    meta_t                   meta;
  } blk_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    meta_t                    meta;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/bavg3_ctrl.sv @@
`default_nettype none

module bavg3_ctrl #(
  parameter int MAX_WIDTH  = bavg3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bavg3_pkg::DEF_MAX_HEIGHT,
  localparam int LINE_DEPTH = MAX_WIDTH / 3,
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [bavg3_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [bavg3_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                          in_acc,
  input  wire logic [bavg3_pkg::PIXEL_W-1:0] pixel_value,
  input  wire logic                          frame_start,
  output bavg3_pkg::line_req_t               req,
  output logic [AW-1:0]                      line_addr
);
  import bavg3_pkg::*;

  localparam int DW  = $clog2(MAX_WIDTH + 1);
  localparam int DH  = $clog2(MAX_HEIGHT + 1);
  localparam int BCW = $clog2(MAX_WIDTH / 3 + 1);
  localparam int BRW = $clog2(MAX_HEIGHT / 3 + 1);
  localparam int CWW = (DW > CFG_W) ? DW : CFG_W;
  localparam int CWH = (DH > CFG_W) ? DH : CFG_W;
  localparam int RST_W  = (RST_DIM > MAX_WIDTH) ? MAX_WIDTH : RST_DIM;
  localparam int RST_H  = (RST_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RST_DIM;
  localparam int RST_BW = RST_W / 3;
  localparam int RST_BH = RST_H / 3;

  function automatic logic [DW-1:0] clamp_w(input logic [CFG_W-1:0] v);
    logic [CWW-1:0] e;
    e = CWW'(v);
    if (e == '0) return DW'(1);
    if (e > CWW'(MAX_WIDTH)) return DW'(MAX_WIDTH);
    return DW'(e);
  endfunction

  function automatic logic [DH-1:0] clamp_h(input logic [CFG_W-1:0] v);
    logic [CWH-1:0] e;
    e = CWH'(v);
    if (e == '0) return DH'(1);
    if (e > CWH'(MAX_HEIGHT)) return DH'(MAX_HEIGHT);
    return DH'(e);
  endfunction

  // x / 3 by reciprocal, exact for any 16-bit x
  function automatic logic [15:0] div3(input logic [15:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'(17'd43691);
    return 16'(p >> 17);
  endfunction

  logic [DW-1:0]  w_r;
  logic [DH-1:0]  h_r;
  logic [BCW-1:0] bw_r;
  logic [BRW-1:0] bh_r;

  logic [DW-1:0]  col_r, col_nxt, cur_col;
  logic [1:0]     sub_r, sub_nxt, cur_sub;
  logic [BCW-1:0] bc_r, bc_nxt, cur_bc;
  logic [DH-1:0]  row_r, row_nxt, cur_row;
  logic [1:0]     band_r, band_nxt, cur_band;
  logic [BRW-1:0] br_r, br_nxt, cur_br;
  logic signed [HSUM_W-1:0] hsum_r, hsum_nxt, cur_hs;

  logic signed [PIXEL_W-1:0] pix;
  logic [DW:0] colp1;
  logic [DH:0] rowp1;
  logic        in_rng;
  logic [DW-1:0] wc;
  logic [DH-1:0] hc;

  assign pix = signed'(pixel_value);
  assign wc  = clamp_w(cfg_wdata);
  assign hc  = clamp_h(cfg_wdata);

  always_comb begin
    // frame_start rewinds the position before this pixel is taken
    cur_col  = frame_start ? '0 : col_r;
    cur_sub  = frame_start ? '0 : sub_r;
    cur_bc   = frame_start ? '0 : bc_r;
    cur_row  = frame_start ? '0 : row_r;
    cur_band = frame_start ? '0 : band_r;
    cur_br   = frame_start ? '0 : br_r;
    cur_hs   = frame_start ? '0 : hsum_r;

    in_rng = (cur_bc < bw_r) && (cur_br < bh_r);

    hsum_nxt = cur_hs;
    if (in_rng) begin
      hsum_nxt = (cur_sub == 2'd0) ? HSUM_W'(pix) : cur_hs + HSUM_W'(pix);
    end

    colp1 = {1'b0, cur_col} + (DW+1)'(1);
    rowp1 = {1'b0, cur_row} + (DH+1)'(1);
    row_nxt  = cur_row;
    band_nxt = cur_band;
    br_nxt   = cur_br;
    if (colp1 >= {1'b0, w_r}) begin
      col_nxt = '0;
      sub_nxt = '0;
      bc_nxt  = '0;
      if (rowp1 >= {1'b0, h_r}) begin
        row_nxt  = '0;
        band_nxt = '0;
        br_nxt   = '0;
      end else begin
        row_nxt  = rowp1[DH-1:0];
        band_nxt = (cur_band == 2'd2) ? 2'd0 : cur_band + 2'd1;
        br_nxt   = (cur_band == 2'd2) ? cur_br + BRW'(1) : cur_br;
      end
    end else begin
      col_nxt = colp1[DW-1:0];
      sub_nxt = (cur_sub == 2'd2) ? 2'd0 : cur_sub + 2'd1;
      bc_nxt  = (cur_sub == 2'd2) ? cur_bc + BCW'(1) : cur_bc;
    end

    req.vld             = in_acc && in_rng && (cur_sub == 2'd2);
    req.first           = (cur_band == 2'd0);
    req.emit            = (cur_band == 2'd2);
    req.hsum            = hsum_nxt;
    req.meta.col        = GRID_W'(cur_bc);
    req.meta.row        = GRID_W'(cur_br);
    req.meta.row_last   = ({1'b0, cur_bc} + (BCW+1)'(1)) == {1'b0, bw_r};
    req.meta.frame_last = req.meta.row_last
                          && (({1'b0, cur_br} + (BRW+1)'(1)) == {1'b0, bh_r});
    line_addr = cur_bc[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= DW'(RST_W);
      h_r    <= DH'(RST_H);
      bw_r   <= BCW'(RST_BW);
      bh_r   <= BRW'(RST_BH);
      col_r  <= '0;
      sub_r  <= '0;
      bc_r   <= '0;
      row_r  <= '0;
      band_r <= '0;
      br_r   <= '0;
      hsum_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_IMAGE_WIDTH: begin
            w_r  <= wc;
            bw_r <= BCW'(div3(16'(wc)));
          end
          REG_IMAGE_HEIGHT: begin
            h_r  <= hc;
            bh_r <= BRW'(div3(16'(hc)));
          end
          default: ;
        endcase
      end
      if (in_acc) begin
        col_r  <= col_nxt;
        sub_r  <= sub_nxt;
        bc_r   <= bc_nxt;
        row_r  <= row_nxt;
        band_r <= band_nxt;
        br_r   <= br_nxt;
        hsum_r <= hsum_nxt;
      end
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_r != 2'd3) && (band_r != 2'd3))
    else $error("column or band phase out of range");

endmodule

`default_nettype wire

@@ hdl/bavg3_line.sv @@
`default_nettype none

module bavg3_line #(
  parameter int MAX_WIDTH = bavg3_pkg::DEF_MAX_WIDTH,
  localparam int LINE_DEPTH = MAX_WIDTH / 3,
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bavg3_pkg::line_req_t req,
  input  wire logic [AW-1:0]        line_addr,
  output bavg3_pkg::blk_t           blk
);
  import bavg3_pkg::*;

  // Per block column partial sums over the current band of three rows
  logic signed [SUM_W-1:0] mem [LINE_DEPTH];
  logic signed [SUM_W-1:0] rd_r;
  logic signed [SUM_W-1:0] total;
  line_req_t               s1_r;
  logic [AW-1:0]           addr_r;
  blk_t                    blk_r;

  // Two updates of one column are at least three pixels apart, so the
  // write-back always lands before the next read of that entry.
  always_ff @(posedge clk) begin
    if (req.vld) begin
      rd_r   <= mem[line_addr];
      addr_r <= line_addr;
    end
    if (s1_r.vld) begin
      mem[addr_r] <= total;
    end
  end

  assign total = s1_r.first ? SUM_W'(s1_r.hsum) : rd_r + SUM_W'(s1_r.hsum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld  <= 1'b0;
      blk_r.vld <= 1'b0;
    end else begin
      s1_r       <= req;
      blk_r.vld  <= s1_r.vld && s1_r.emit;
      blk_r.total <= total;
      blk_r.meta <= s1_r.meta;
    end
  end

  assign blk = blk_r;

  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.vld && s1_r.vld))
    else $error("line store read overlaps pending write-back");

endmodule

`default_nettype wire

@@ hdl/bavg3_div9.sv @@
`default_nettype none

module bavg3_div9 (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bavg3_pkg::blk_t blk,
  output logic                 res_vld,
  output bavg3_pkg::res_t      res
);
  import bavg3_pkg::*;

  // |sum| * 16 stays below 2^23; ceil(2^27 / 9) gives exact floor division
  localparam int DIV_IN_W = SUM_W + 3;
  localparam int A_W      = SUM_W + 4;
  localparam int DIV_K    = DIV_IN_W + 4;
  localparam int RECIP_W  = DIV_IN_W + 1;
  localparam int PROD_W   = A_W + RECIP_W;
  localparam longint unsigned RECIP9_L = ((64'd1 << DIV_K) / 9) + 1;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(RECIP9_L);

  logic                neg;
  logic [SUM_W-1:0]    mag;
  logic [A_W-1:0]      a;
  logic [PROD_W-1:0]   prod_r;
  logic                neg_r;
  logic                p_vld_r;
  meta_t               p_meta_r;
  logic [MEAN_W:0]     q;
  logic                res_vld_r;
  res_t                res_r;

  assign neg = blk.total[SUM_W-1];
  assign mag = neg ? SUM_W'(-blk.total) : SUM_W'(blk.total);
  assign a   = {mag, 4'b0000};
  assign q   = prod_r[DIV_K +: MEAN_W + 1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      p_vld_r   <= blk.vld;
      res_vld_r <= p_vld_r;
    end
    prod_r     <= PROD_W'(a) * PROD_W'(RECIP9);
    neg_r      <= neg;
    p_meta_r   <= blk.meta;
    res_r.mean <= MEAN_W'(neg_r ? -q : q);  // truncation toward zero
    res_r.meta <= p_meta_r;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

`default_nettype wire

@@ hdl/bavg3_ofifo.sv @@
`default_nettype none

module bavg3_ofifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            claim,   // accepted pixel that will produce a result
  input  wire logic            push,
  input  wire bavg3_pkg::res_t din,
  output logic                 credit_ok,
  output logic                 out_vld,
  input  wire logic            out_rdy,
  output bavg3_pkg::res_t      dout
);
  import bavg3_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);

  res_t           q [OUT_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r, pend_r;
  logic           pop;

  assign pop       = out_vld && out_rdy;
  assign out_vld   = (cnt_r != '0);
  assign dout      = q[rp_r];
  // results still in the pipeline plus queued ones never exceed the queue
  assign credit_ok = (pend_r < (PW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      pend_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      cnt_r  <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
      pend_r <= pend_r + (PW+1)'(claim) - (PW+1)'(pop);
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < (PW+1)'(OUT_DEPTH)) || pop)
    else $error("output queue overflow");

  a_cnt_le_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= pend_r) && (pend_r <= (PW+1)'(OUT_DEPTH)))
    else $error("queued results exceed outstanding count");

endmodule

`default_nettype wire

@@ hdl/block_average_3x3_downsampler_core.sv @@
`default_nettype none
// 3x3 average pooling, stride 3, on a raster-order pixel stream.
// in_*: one signed pixel per request, in_tuser flags the first pixel of a
//   frame. A frame also rolls over on its own after image_width x
//   image_height pixels.
// out_*: one mean per complete 3x3 block (lower right pixel arrives),
//   in block order; partial columns and rows at the edges are dropped.
//   Mean is sum*16/9, signed with four fraction bits, truncated to zero.
// cfg_*: register 0 image_width, register 1 image_height; write while idle.
// Throughput: one pixel per clock while in_tready is high. The line store
//   does one read at the completing pixel of a block row and its write-back
//   in the cycle after, so an update needs a single memory port slot per three pixels.
// Path: a result passes the line store read register, the block register, the
//   divider product and result registers and the output queue, then shows on out_tvalid.
// Stall: results wait in a four-entry output queue; in_tready drops once
//   four results are outstanding, so a stalled receiver backs up the input
//   only after that. No result is dropped.
// Reset: position and partial row sum clear, size registers return to
//   1024 x 1024 (limited to the maximum); the line store needs no clearing.
module block_average_3x3_downsampler_core #(
  parameter int MAX_WIDTH  = bavg3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bavg3_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bavg3_pkg::CFG_AW-1:0]      cfg_addr,
  input  wire logic [bavg3_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bavg3_pkg::PIXEL_W-1:0]     in_tdata,   // [15:0] pixel_value
  input  wire logic                              in_tuser,   // frame_start
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [bavg3_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [19:0] block_mean,
                                                             // [28:20] block_column,
                                                             // [37:29] block_row
  output logic                                   out_tlast,  // row_last
  output logic                                   out_tuser   // frame_last
);
  import bavg3_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 3;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int PAD_W = OUT_TDATA_W - MEAN_W - 2 * GRID_W;

  logic          in_acc;
  line_req_t     req;
  logic [AW-1:0] line_addr;
  blk_t          blk;
  logic          res_vld;
  res_t          res;
  res_t          head;
  logic          credit_ok;

  assign in_tready = credit_ok;
  assign in_acc    = in_tvalid && in_tready;

  bavg3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_acc     (in_acc),
    .pixel_value(in_tdata),
    .frame_start(in_tuser),
    .req        (req),
    .line_addr  (line_addr)
  );

  bavg3_line #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .line_addr(line_addr),
    .blk      (blk)
  );

  bavg3_div9 u_div9 (
    .clk    (clk),
    .rst_n  (rst_n),
    .blk    (blk),
    .res_vld(res_vld),
    .res    (res)
  );

  bavg3_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .claim    (req.vld && req.emit),
    .push     (res_vld),
    .din      (res),
    .credit_ok(credit_ok),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .dout     (head)
  );

  assign out_tdata = {{PAD_W{1'b0}}, head.meta.row, head.meta.col, head.mean};
  assign out_tlast = head.meta.row_last;
  assign out_tuser = head.meta.frame_last;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  import bavg3_pkg::*;

  localparam int LINE_ENTRIES = DEF_MAX_WIDTH / 3;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_PIXELS = 550;

  typedef struct {
    logic signed [MEAN_W-1:0] mean;
    logic [GRID_W-1:0]        col;
    logic [GRID_W-1:0]        row;
    logic                     row_last;
    logic                     frame_last;
  } block_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_addr = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [PIXEL_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  block_average_3x3_downsampler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] pixel_value
    .in_tuser   (in_tuser),   // frame_start
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [19:0] block_mean, [28:20] block_column, [37:29] block_row
    .out_tlast  (out_tlast),  // row_last
    .out_tuser  (out_tuser)   // frame_last
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [CFG_W-1:0] size_w = 11'd1024;
  logic [CFG_W-1:0] size_h = 11'd1024;
  longint band_sums [LINE_ENTRIES];
  longint row_sum = 0;
  int pos_col = 0;
  int pos_row = 0;
  int sent_pixels = 0;
  block_result_t pending_blocks[$];
  block_result_t want;

  int mismatches = 0;
  int stall_cycles = 0;

  // traffic shaping
  int gap_max = 0;
  int burst_max = 1;
  int burst_left = 0;
  logic [15:0] ready_mask = 16'hffff;
  logic [3:0] mask_phase = '0;

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  function automatic void pool_pixel(logic [PIXEL_W-1:0] px, logic new_frame);
    int w, h, bc;
    longint total;
    block_result_t r;
    w = clamp_dim(size_w, DEF_MAX_WIDTH);
    h = clamp_dim(size_h, DEF_MAX_HEIGHT);
    if (new_frame) begin
      pos_col = 0;
      pos_row = 0;
      row_sum = 0;
    end
    if (pos_col < (w / 3) * 3 && pos_row < (h / 3) * 3) begin
      bc = pos_col / 3;
      row_sum = (pos_col % 3 == 0) ? longint'($signed(px)) : row_sum + longint'($signed(px));
      if (pos_col % 3 == 2 && bc < LINE_ENTRIES) begin
        total = (pos_row % 3 == 0) ? row_sum : band_sums[bc] + row_sum;
        band_sums[bc] = total;
        if (pos_row % 3 == 2) begin
          r.mean = MEAN_W'((total * 16) / 9);  // truncates toward zero
          r.col = GRID_W'(bc);
          r.row = GRID_W'(pos_row / 3);
          r.row_last = (bc + 1 == w / 3);
          r.frame_last = r.row_last && (pos_row / 3 + 1 == h / 3);
          pending_blocks.push_back(r);
        end
      end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0d, expected %0d", what, got, exp_v);
    mismatches++;
  endtask

  task automatic set_traffic(int gap, int burst, logic [15:0] mask);
    gap_max = gap;
    burst_max = burst;
    burst_left = 0;
    ready_mask = mask;
  endtask

  task automatic send_pixel(logic [PIXEL_W-1:0] px, logic new_frame);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= px;
    in_tuser <= new_frame;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_pixels++;
    pool_pixel(px, new_frame);
  endtask

  // stop sending, let every pending block come out, then cover the pipeline latency
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_addr <= REG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    size_w = w;
    cfg_addr <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    size_h = h;
    cfg_we <= 1'b0;
  endtask

  task automatic test_extreme_blocks();
    set_traffic(0, 1, 16'hffff);
    set_size(11'd3, 11'd3);
    for (int i = 0; i < 9; i++) send_pixel(16'h8000, i == 0);
    // second frame starts by wrap-around, no frame flag
    for (int i = 0; i < 9; i++) send_pixel(16'h7fff, 1'b0);
    // sum of -1 must truncate to -1, not floor to -2
    for (int i = 0; i < 9; i++) send_pixel((i == 0) ? 16'hffff : 16'h0000, i == 0);
  endtask

  task automatic test_tiny_images();
    set_traffic(2, 4, 16'hb6db);
    set_size(11'd0, 11'd2047);
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel(), i == 0);
    set_size(11'd2, 11'd0);
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel(), i == 0);
    set_size(11'd1, 11'd1);
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel(), i == 0);
    set_size(11'd2, 11'd2);
    for (int i = 0; i < 8; i++) send_pixel(rand_pixel(), i == 0);
  endtask

  task automatic test_wide_line();
    set_traffic(3, 12, 16'($urandom) | 16'h0101);
    set_size(11'd72, 11'd3);
    for (int i = 0; i < 3 * 72; i++) send_pixel(rand_pixel(), i == 0);
  endtask

  task automatic test_tall_frame();
    set_traffic(0, 1, 16'h00ff);
    set_size(11'd3, 11'd72);
    for (int i = 0; i < 3 * 72; i++) send_pixel(rand_pixel(), i == 0);
  endtask

  task automatic test_resize_mid_frame();
    set_traffic(1, 6, 16'hffff);
    set_size(11'd12, 11'd9);
    // stop inside the second band, row 4 column 5
    for (int i = 0; i < 53; i++) send_pixel(rand_pixel(), i == 0);
    set_size(11'd6, 11'd9);
    for (int i = 0; i < 54; i++) send_pixel(rand_pixel(), 1'b0);
    // now at row 4 again: shrinking the height skips to the next frame
    set_size(11'd6, 11'd3);
    for (int i = 0; i < 30; i++) send_pixel(rand_pixel(), 1'b0);
  endtask

  task automatic test_random_frames();
    int start, phase, w, h, n, pause_at;
    logic [15:0] mask;
    start = sent_pixels;
    phase = 0;
    while (sent_pixels - start < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      case ($urandom_range(0, 3))
        0: mask = 16'hffff;
        1: mask = 16'($urandom) & 16'($urandom) | 16'h0001;
        default: mask = 16'($urandom) | 16'h8000;
      endcase
      set_traffic(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8),
                  $urandom_range(1, 16), mask);
      set_size(CFG_W'(w), CFG_W'(h));
      n = $urandom_range(1, 3) * w * h;
      if (n > RANDOM_PIXELS - (sent_pixels - start)) n = RANDOM_PIXELS - (sent_pixels - start);
      pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ? n / 2 : -1;
      for (int i = 0; i < n; i++) begin
        if (i == pause_at && i != 0) wait_drained();
        // stray frame starts break the current frame
        send_pixel(rand_pixel(), i == 0 || $urandom_range(0, 49) == 0);
      end
      phase++;
    end
  endtask

  always @(posedge clk) begin
    mask_phase <= mask_phase + 4'd1;
    out_tready <= ready_mask[mask_phase];
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch("block with nothing pending, mean",
                        longint'($signed(out_tdata[MEAN_W-1:0])), longint'(0));
      end else begin
        want = pending_blocks.pop_front();
        if (out_tdata[MEAN_W-1:0] !== want.mean)
          report_mismatch("block_mean", longint'($signed(out_tdata[MEAN_W-1:0])),
                          longint'(want.mean));
        if (out_tdata[MEAN_W+GRID_W-1:MEAN_W] !== want.col)
          report_mismatch("block_column", longint'(out_tdata[MEAN_W+GRID_W-1:MEAN_W]),
                          longint'(want.col));
        if (out_tdata[MEAN_W+2*GRID_W-1:MEAN_W+GRID_W] !== want.row)
          report_mismatch("block_row",
                          longint'(out_tdata[MEAN_W+2*GRID_W-1:MEAN_W+GRID_W]),
                          longint'(want.row));
        if (out_tlast !== want.row_last)
          report_mismatch("row_last", longint'(out_tlast), longint'(want.row_last));
        if (out_tuser !== want.frame_last)
          report_mismatch("frame_last", longint'(out_tuser), longint'(want.frame_last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extreme_blocks();
    test_tiny_images();
    test_wide_line();
    test_tall_frame();
    test_resize_mid_frame();
    test_random_frames();
    wait_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
